[hdl/kac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kac_pkg
// Shared types and keyword tables for the keyword alert classifier.
// ----------------------------------------------------------------------------
package kac_pkg;

    localparam int NUM_CLASSES = 13;
    localparam int NUM_KW      = 20;
    localparam int HIST_LEN    = 21;
    localparam int WIN_LEN     = HIST_LEN + 1;

    typedef logic [7:0]             byte_t;
    typedef logic [3:0]             class_t;
    typedef logic [NUM_CLASSES-1:0] class_vec_t;
    typedef logic [WIN_LEN*8-1:0]   kw_text_t;
    typedef logic [4:0]             kw_len_t;

    // Control handed from the top level to every history cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // Alert classes, in priority order (lowest code wins)
    localparam class_t CLS_ICMP   = 4'd0;
    localparam class_t CLS_HTTP   = 4'd1;
    localparam class_t CLS_DNS    = 4'd2;
    localparam class_t CLS_FTP    = 4'd3;
    localparam class_t CLS_SSH    = 4'd4;
    localparam class_t CLS_TELNET = 4'd5;
    localparam class_t CLS_LOGIN  = 4'd6;
    localparam class_t CLS_SYN    = 4'd7;
    localparam class_t CLS_FIN    = 4'd8;
    localparam class_t CLS_RST    = 4'd9;
    localparam class_t CLS_SQL    = 4'd10;
    localparam class_t CLS_XSS    = 4'd11;
    localparam class_t CLS_TRAV   = 4'd12;

    // Keyword text, right aligned: the last character sits in bits [7:0]
    localparam kw_text_t KW_TEXT [NUM_KW] = '{
        "icmp", "http", "dns", "ftp", "ssh", "telnet",
        "login failed", "authentication failure",
        "syn", "fin", "rst",
        "select", "drop", "insert", "update",
        "<script", "alert(", "onerror=",
        "../", "/etc/passwd"
    };

    localparam kw_len_t KW_LEN [NUM_KW] = '{
        5'd4, 5'd4, 5'd3, 5'd3, 5'd3, 5'd6,
        5'd12, 5'd22,
        5'd3, 5'd3, 5'd3,
        5'd6, 5'd4, 5'd6, 5'd6,
        5'd7, 5'd6, 5'd8,
        5'd3, 5'd11
    };

    localparam class_t KW_CLASS [NUM_KW] = '{
        CLS_ICMP, CLS_HTTP, CLS_DNS, CLS_FTP, CLS_SSH, CLS_TELNET,
        CLS_LOGIN, CLS_LOGIN,
        CLS_SYN, CLS_FIN, CLS_RST,
        CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL,
        CLS_XSS, CLS_XSS, CLS_XSS,
        CLS_TRAV, CLS_TRAV
    };

    // Code letter per class; two-letter codes keep only the first letter
    localparam byte_t CLASS_LETTER [NUM_CLASSES] = '{
        "I", "H", "D", "F", "S", "T", "L", "S", "F", "R", "Q", "X", "U"
    };

endpackage

[hdl/kac_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kac_cell
// One byte of the history window; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module kac_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  kac_pkg::cell_ctrl_t ctrl,
    input  kac_pkg::byte_t     din,
    output kac_pkg::byte_t     dout
);

    kac_pkg::byte_t data_reg;
    kac_pkg::byte_t data_next;

    // Clear at chunk end wins over a shift
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.clear)
        begin
            data_next = '0;
        end
        else if (ctrl.shift)
        begin
            data_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[hdl/kac_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kac_match
// Parallel keyword comparators over the current byte and the history cells.
// ----------------------------------------------------------------------------
module kac_match
(
    input  kac_pkg::byte_t                           cur_byte,
    input  logic [kac_pkg::HIST_LEN-1:0][7:0]        hist,
    output kac_pkg::class_vec_t                      hits
);

    kac_pkg::byte_t win [kac_pkg::WIN_LEN];

    // Window newest first: slot 0 is the incoming byte
    always_comb
    begin
        win[0] = cur_byte;
        for (int i = 1; i < kac_pkg::WIN_LEN; i++)
        begin
            win[i] = hist[i-1];
        end
    end

    // Each keyword must end at the incoming byte
    always_comb
    begin
        logic kw_hit;
        hits = '0;
        for (int k = 0; k < kac_pkg::NUM_KW; k++)
        begin
            kw_hit = 1'b1;
            for (int i = 0; i < kac_pkg::WIN_LEN; i++)
            begin
                if (i < int'(kac_pkg::KW_LEN[k]))
                begin
                    if (win[i] != kac_pkg::KW_TEXT[k][8*i +: 8])
                    begin
                        kw_hit = 1'b0;
                    end
                end
            end
            if (kw_hit)
            begin
                hits[kac_pkg::KW_CLASS[k]] = 1'b1;
            end
        end
    end

endmodule

[hdl/keyword_alert_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_alert_classifier
// Keyword matcher over log chunks with a shifting row of history cells.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters one byte per transfer on text_byte/chunk_end (text_valid,
//   text_ready). Letters fold to lower case and shift into a row of 21 byte
//   cells; twenty keyword comparators check the row plus the new byte in
//   the same cycle and set per-class found flags. A zero byte stops matching
//   until the chunk ends.
//   The transfer that carries chunk_end emits at most one alert on
//   alert_class/alert_letter (alert_valid, alert_ready): the found class
//   with the lowest code. It appears in the cycle after that transfer;
//   chunks with no class found give no alert. Cells and flags clear then.
//   Throughput is one byte per cycle unless stalled; the comparator row is
//   combinational. One output register holds a pending alert; text_ready
//   stays high unless that register is full and alert_ready is low, so a
//   stalled receiver only holds back input while an alert waits.
//   Reset clears the cells, the flags, the terminator mark and the output.
// ----------------------------------------------------------------------------
module keyword_alert_classifier
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           text_valid,
    output logic           text_ready,
    input  logic [7:0]     text_byte,
    input  logic           chunk_end,
    output logic           alert_valid,
    input  logic           alert_ready,
    output logic [3:0]     alert_class,
    output logic [7:0]     alert_letter
);

    logic                              accept;
    logic                              match_en;
    kac_pkg::byte_t                    folded;
    logic [kac_pkg::HIST_LEN-1:0][7:0] hist;
    kac_pkg::class_vec_t               hits;
    kac_pkg::class_vec_t               found_now;
    kac_pkg::cell_ctrl_t               cell_ctrl;
    kac_pkg::class_t                   top_class;

    kac_pkg::class_vec_t found_reg;
    kac_pkg::class_vec_t found_next;
    logic                seen_term_reg;
    logic                seen_term_next;
    logic                alert_valid_reg;
    logic                alert_valid_next;
    kac_pkg::class_t     alert_class_reg;
    kac_pkg::class_t     alert_class_next;
    kac_pkg::byte_t      alert_letter_reg;
    kac_pkg::byte_t      alert_letter_next;

    // Handshake
    assign text_ready = !alert_valid_reg || alert_ready;
    assign accept     = text_valid && text_ready;
    assign match_en   = !seen_term_reg && (text_byte != 8'd0);

    // Case folding
    assign folded = ((text_byte >= "A") && (text_byte <= "Z")) ?
                    (text_byte | 8'h20) : text_byte;

    // Cell control
    assign cell_ctrl.clear = accept && chunk_end;
    assign cell_ctrl.shift = accept && match_en;

    // History row: cell 0 holds the newest byte
    genvar gi;
    generate
        for (gi = 0; gi < kac_pkg::HIST_LEN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                kac_cell u_cell
                (
                    .clk  (clk),
                    .rst_n(rst_n),
                    .ctrl (cell_ctrl),
                    .din  (folded),
                    .dout (hist[gi])
                );
            end
            else
            begin : g_body
                kac_cell u_cell
                (
                    .clk  (clk),
                    .rst_n(rst_n),
                    .ctrl (cell_ctrl),
                    .din  (hist[gi-1]),
                    .dout (hist[gi])
                );
            end
        end
    endgenerate

    kac_match u_match
    (
        .cur_byte(folded),
        .hist    (hist),
        .hits    (hits)
    );

    assign found_now = match_en ? (found_reg | hits) : found_reg;

    // Priority pick: lowest class code wins
    always_comb
    begin
        top_class = '0;
        for (int c = kac_pkg::NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (found_now[c])
            begin
                top_class = kac_pkg::class_t'(c);
            end
        end
    end

    // Next-state logic
    always_comb
    begin
        found_next        = found_reg;
        seen_term_next    = seen_term_reg;
        alert_valid_next  = alert_valid_reg;
        alert_class_next  = alert_class_reg;
        alert_letter_next = alert_letter_reg;

        if (alert_valid_reg && alert_ready)
        begin
            alert_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (chunk_end)
            begin
                found_next     = '0;
                seen_term_next = 1'b0;
                if (found_now != '0)
                begin
                    alert_valid_next  = 1'b1;
                    alert_class_next  = top_class;
                    alert_letter_next = kac_pkg::CLASS_LETTER[top_class];
                end
            end
            else
            begin
                found_next = found_now;
                if (text_byte == 8'd0)
                begin
                    seen_term_next = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg       <= '0;
            seen_term_reg   <= 1'b0;
            alert_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg       <= found_next;
            seen_term_reg   <= seen_term_next;
            alert_valid_reg <= alert_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alert_class_reg  <= '0;
            alert_letter_reg <= '0;
        end
        else
        begin
            alert_class_reg  <= alert_class_next;
            alert_letter_reg <= alert_letter_next;
        end
    end

    assign alert_valid  = alert_valid_reg;
    assign alert_class  = alert_class_reg;
    assign alert_letter = alert_letter_reg;

endmodule
